[rtl/lsd_radix_sort_engine_macros.svh]
// Assertion macros for the LSD radix sort engine.
// Used by the top level only; no other dependencies.
`ifndef LSD_RADIX_SORT_ENGINE_MACROS_SVH
`define LSD_RADIX_SORT_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsd_radix_sort_engine check failed");

// Next-cycle implication, disabled during reset
`define LSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsd_radix_sort_engine check failed");

`endif

[rtl/lsd_pkg.sv]
// Shared constants for the LSD radix sort engine.
// No dependencies.
package lsd_pkg;

    localparam int KEY_W        = 31;
    localparam int RADIX_W      = 9;
    localparam int NDIG_W       = 6;
    localparam int MAX_ITEMS    = 64;
    localparam int MAX_RADIX    = 256;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [RADIX_W-1:0] RADIX_RST = 9'd10;
    localparam logic [NDIG_W-1:0]  NDIG_RST  = 6'd10;

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_RADIX      = 1'b0,
        REG_NUM_DIGITS = 1'b1
    } reg_idx_t;

endpackage

[rtl/lsd_if.sv]
// Stream channel interfaces for key input and sorted output.
// Depends on lsd_pkg.
interface lsd_in_if;
    logic                        valid;
    logic                        ready;
    logic [lsd_pkg::KEY_W-1:0]   key;
    logic                        last_item;

    modport source (output valid, key, last_item, input ready);
    modport sink   (input valid, key, last_item, output ready);
endinterface

interface lsd_out_if;
    logic                        valid;
    logic                        ready;
    logic [lsd_pkg::KEY_W-1:0]   sorted_key;
    logic                        last_out;
    logic                        overflow;

    modport source (output valid, sorted_key, last_out, overflow, input ready);
    modport sink   (input valid, sorted_key, last_out, overflow, output ready);
endinterface

[rtl/lsd_ram.sv]
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module lsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/lsd_div.sv]
// Restoring divider, one quotient bit per cycle, zero dividend finishes at once.
// Depends on lsd_pkg for the key width.
module lsd_div #(
    parameter int MAX_RADIX = lsd_pkg::MAX_RADIX
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [lsd_pkg::KEY_W-1:0]        dividend,
    input  logic [$clog2(MAX_RADIX+1)-1:0]   divisor,
    output logic                             done,
    output logic [lsd_pkg::KEY_W-1:0]        quotient,
    output logic [$clog2(MAX_RADIX)-1:0]     remainder
);

    localparam int KW  = lsd_pkg::KEY_W;
    localparam int RW  = $clog2(MAX_RADIX + 1);
    localparam int DW  = $clog2(MAX_RADIX);
    localparam int ITW = $clog2(KW);

    logic [KW-1:0]  q_reg, q_next;
    logic [RW-1:0]  rem_reg, rem_next;
    logic [ITW-1:0] it_reg, it_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [RW:0]    trial;

    assign trial = {rem_reg, q_reg[KW-1]};

    // Iteration step
    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        it_next   = it_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = dividend;
            rem_next = '0;
            it_next  = ITW'(KW - 1);
            if (dividend == '0)
            begin
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = RW'(trial - {1'b0, divisor});
                q_next   = {q_reg[KW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[RW-1:0];
                q_next   = {q_reg[KW-2:0], 1'b0};
            end
            it_next = it_reg - ITW'(1);
            if (it_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg[DW-1:0];

endmodule

[rtl/lsd_radix_sort_engine.sv]
// LSD radix sort engine: loads one key per cycle, sorts on the last key, emits in order.
// Per pass: setup, clear of the r digit counts, a count loop (per key read, latch, serial
// divide and count write), a read/write prefix sweep, then per key a scatter read, latch and
// write. Emit reads, latches and outputs each key; the first result follows the check, read
// and latch after the last pass. Reset clears control, count and overflow; radix and
// num_digits reset to 10. Key stores need no clearing; each pass clears its digit counts.
module lsd_radix_sort_engine #(
    parameter int MAX_ITEMS = lsd_pkg::MAX_ITEMS,
    parameter int MAX_RADIX = lsd_pkg::MAX_RADIX
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lsd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lsd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lsd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    lsd_in_if.sink                            in_ch,
    lsd_out_if.source                         out_ch
);

    `include "lsd_radix_sort_engine_macros.svh"

    localparam int KW = lsd_pkg::KEY_W;
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int DW = $clog2(MAX_RADIX);
    localparam int RW = $clog2(MAX_RADIX + 1);
    localparam int EW = 2 * KW + DW;
    localparam int NW = lsd_pkg::NDIG_W;

    typedef enum logic [14:0]
    {
        ST_LOAD     = 15'b000000000000001,
        ST_PASS     = 15'b000000000000010,
        ST_CLR      = 15'b000000000000100,
        ST_CNT_RD   = 15'b000000000001000,
        ST_CNT_LAT  = 15'b000000000010000,
        ST_CNT_DIV  = 15'b000000000100000,
        ST_CNT_WR   = 15'b000000001000000,
        ST_PRE_RD   = 15'b000000010000000,
        ST_PRE_WR   = 15'b000000100000000,
        ST_SC_RD    = 15'b000001000000000,
        ST_SC_LAT   = 15'b000010000000000,
        ST_SC_WR    = 15'b000100000000000,
        ST_EMIT_RD  = 15'b001000000000000,
        ST_EMIT_LAT = 15'b010000000000000,
        ST_EMIT_OUT = 15'b100000000000000
    } state_t;

    state_t                         state_reg, state_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic                           ovf_reg, ovf_next;
    logic                           bank_reg, bank_next;
    logic [NW-1:0]                  pass_reg, pass_next;
    logic [CW-1:0]                  ki_reg, ki_next;
    logic [DW-1:0]                  ci_reg, ci_next;
    logic [CW-1:0]                  acc_reg, acc_next;
    logic [EW-1:0]                  ent_reg, ent_next;
    logic [DW-1:0]                  dig_reg, dig_next;
    logic [lsd_pkg::RADIX_W-1:0]    radix_reg;
    logic [NW-1:0]                  ndig_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [KW-1:0]                  out_key_reg, out_key_next;
    logic                           out_last_reg, out_last_next;
    logic                           out_ovf_reg, out_ovf_next;

    logic [RW-1:0]  r_eff;
    logic [DW-1:0]  r_last;
    logic           in_xfer, out_xfer, cfg_wr;

    logic [AW-1:0]  src_addr, dst_addr, a_addr, b_addr;
    logic           src_we, dst_we, a_we, b_we;
    logic [EW-1:0]  src_wdata, dst_wdata, a_wdata, b_wdata, a_rdata, b_rdata, src_rdata;
    logic [DW-1:0]  c_addr;
    logic           c_we;
    logic [CW-1:0]  c_wdata, c_rdata, pos;

    logic           div_start, div_done;
    logic [KW-1:0]  div_quo;
    logic [DW-1:0]  div_rem;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (lsd_pkg::reg_idx_t'(paddr[2]))
            lsd_pkg::REG_RADIX:      prdata = {{(lsd_pkg::APB_DATA_W-lsd_pkg::RADIX_W){1'b0}},
                                               radix_reg};
            lsd_pkg::REG_NUM_DIGITS: prdata = {{(lsd_pkg::APB_DATA_W-NW){1'b0}}, ndig_reg};
            default:                 prdata = '0;
        endcase
    end

    // Radix clamped to the supported range
    always_comb
    begin
        priority if (radix_reg < lsd_pkg::RADIX_W'(2))
        begin
            r_eff = RW'(2);
        end
        else if (radix_reg > lsd_pkg::RADIX_W'(MAX_RADIX))
        begin
            r_eff = RW'(MAX_RADIX);
        end
        else
        begin
            r_eff = RW'(radix_reg);
        end
    end
    assign r_last = DW'(r_eff - RW'(1));

    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign out_xfer = out_valid_reg && out_ch.ready;
    assign in_ch.ready = (state_reg == ST_LOAD);

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sorted_key = out_key_reg;
    assign out_ch.last_out   = out_last_reg;
    assign out_ch.overflow   = out_ovf_reg;

    // Bank select: source holds the current order, destination takes the scatter
    assign src_rdata = bank_reg ? b_rdata : a_rdata;
    always_comb
    begin
        if (bank_reg)
        begin
            b_addr = src_addr; b_we = src_we; b_wdata = src_wdata;
            a_addr = dst_addr; a_we = dst_we; a_wdata = dst_wdata;
        end
        else
        begin
            a_addr = src_addr; a_we = src_we; a_wdata = src_wdata;
            b_addr = dst_addr; b_we = dst_we; b_wdata = dst_wdata;
        end
    end

    assign pos = c_rdata - CW'(1);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        bank_next      = bank_reg;
        pass_next      = pass_reg;
        ki_next        = ki_reg;
        ci_next        = ci_reg;
        acc_next       = acc_reg;
        ent_next       = ent_reg;
        dig_next       = dig_reg;
        out_valid_next = out_valid_reg;
        out_key_next   = out_key_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        src_addr  = ki_reg[AW-1:0];
        src_we    = 1'b0;
        src_wdata = ent_reg;
        dst_addr  = pos[AW-1:0];
        dst_we    = 1'b0;
        dst_wdata = {ent_reg[EW-1:DW], {DW{1'b0}}};
        c_addr    = ci_reg;
        c_we      = 1'b0;
        c_wdata   = '0;
        div_start = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (cnt_reg < CW'(MAX_ITEMS))
                    begin
                        src_we    = 1'b1;
                        src_addr  = cnt_reg[AW-1:0];
                        src_wdata = {in_ch.key, in_ch.key, {DW{1'b0}}};
                        cnt_next  = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_ch.last_item)
                    begin
                        pass_next  = '0;
                        state_next = ST_PASS;
                    end
                end
            end
            ST_PASS:
            begin
                ki_next = '0;
                ci_next = '0;
                if (pass_reg == ndig_reg)
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_CLR;
                end
            end
            ST_CLR:
            begin
                c_we = 1'b1;
                if (ci_reg == r_last)
                begin
                    ki_next    = '0;
                    state_next = ST_CNT_RD;
                end
                else
                begin
                    ci_next = ci_reg + DW'(1);
                end
            end
            ST_CNT_RD:
            begin
                state_next = ST_CNT_LAT;
            end
            ST_CNT_LAT:
            begin
                ent_next   = src_rdata;
                div_start  = 1'b1;
                state_next = ST_CNT_DIV;
            end
            ST_CNT_DIV:
            begin
                if (div_done)
                begin
                    // keep the remaining quotient and this pass's digit with the key
                    src_we     = 1'b1;
                    src_wdata  = {ent_reg[EW-1 -: KW], div_quo, div_rem};
                    c_addr     = div_rem;
                    dig_next   = div_rem;
                    state_next = ST_CNT_WR;
                end
            end
            ST_CNT_WR:
            begin
                c_we    = 1'b1;
                c_addr  = dig_reg;
                c_wdata = c_rdata + CW'(1);
                if ((ki_reg + CW'(1)) == cnt_reg)
                begin
                    ci_next    = '0;
                    acc_next   = '0;
                    state_next = ST_PRE_RD;
                end
                else
                begin
                    ki_next    = ki_reg + CW'(1);
                    state_next = ST_CNT_RD;
                end
            end
            ST_PRE_RD:
            begin
                state_next = ST_PRE_WR;
            end
            ST_PRE_WR:
            begin
                c_we     = 1'b1;
                c_wdata  = acc_reg + c_rdata;
                acc_next = acc_reg + c_rdata;
                if (ci_reg == r_last)
                begin
                    ki_next    = cnt_reg;
                    state_next = ST_SC_RD;
                end
                else
                begin
                    ci_next    = ci_reg + DW'(1);
                    state_next = ST_PRE_RD;
                end
            end
            ST_SC_RD:
            begin
                src_addr   = AW'(ki_reg - CW'(1));
                state_next = ST_SC_LAT;
            end
            ST_SC_LAT:
            begin
                ent_next   = src_rdata;
                c_addr     = src_rdata[DW-1:0];
                state_next = ST_SC_WR;
            end
            ST_SC_WR:
            begin
                dst_we  = 1'b1;
                c_we    = 1'b1;
                c_addr  = ent_reg[DW-1:0];
                c_wdata = pos;
                ki_next = ki_reg - CW'(1);
                if (ki_reg == CW'(1))
                begin
                    bank_next  = !bank_reg;
                    pass_next  = pass_reg + NW'(1);
                    state_next = ST_PASS;
                end
                else
                begin
                    state_next = ST_SC_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LAT;
            end
            ST_EMIT_LAT:
            begin
                out_valid_next = 1'b1;
                out_key_next   = src_rdata[EW-1 -: KW];
                out_last_next  = ((ki_reg + CW'(1)) == cnt_reg);
                out_ovf_next   = ovf_reg;
                state_next     = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (out_xfer)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        ki_next    = ki_reg + CW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            bank_reg      <= 1'b0;
            pass_reg      <= '0;
            ki_reg        <= '0;
            ci_reg        <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            radix_reg     <= lsd_pkg::RADIX_RST;
            ndig_reg      <= lsd_pkg::NDIG_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            bank_reg      <= bank_next;
            pass_reg      <= pass_next;
            ki_reg        <= ki_next;
            ci_reg        <= ci_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                unique case (lsd_pkg::reg_idx_t'(paddr[2]))
                    lsd_pkg::REG_RADIX:      radix_reg <= pwdata[lsd_pkg::RADIX_W-1:0];
                    lsd_pkg::REG_NUM_DIGITS: ndig_reg  <= pwdata[NW-1:0];
                    default:                 radix_reg <= radix_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        dig_reg      <= dig_next;
        out_key_reg  <= out_key_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // Key stores (ping-pong) and digit count memory
    lsd_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_store_a (
        .clk   (clk),
        .we    (a_we),
        .addr  (a_addr),
        .wdata (a_wdata),
        .rdata (a_rdata)
    );

    lsd_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_store_b (
        .clk   (clk),
        .we    (b_we),
        .addr  (b_addr),
        .wdata (b_wdata),
        .rdata (b_rdata)
    );

    lsd_ram #(.WIDTH(CW), .DEPTH(MAX_RADIX)) u_counts (
        .clk   (clk),
        .we    (c_we),
        .addr  (c_addr),
        .wdata (c_wdata),
        .rdata (c_rdata)
    );

    lsd_div #(.MAX_RADIX(MAX_RADIX)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (src_rdata[DW +: KW]),
        .divisor   (r_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Checks
    `LSD_ASSERT_IMPL(a_no_in_while_out, clk, rst_n, out_valid_reg, !in_ch.ready)
    `LSD_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(MAX_ITEMS))
    `LSD_ASSERT_NEXT(a_batch_clear, clk, rst_n, out_xfer && out_last_reg,
                     cnt_reg == '0 && !ovf_reg && in_ch.ready)
    `LSD_ASSERT_IMPL(a_div_in_count, clk, rst_n, div_done, state_reg == ST_CNT_DIV)

endmodule

[bench/lsd_radix_sort_engine_tb.sv]
// Self-checking bench for lsd_radix_sort_engine: a directed table, then random batches
// under three idling mixes, checked against an in-bench radix sorter or typed expectations.
// Depends on lsd_pkg, lsd_in_if and lsd_out_if from the RTL.
module lsd_radix_sort_engine_tb;

    localparam int KEY_W      = lsd_pkg::KEY_W;
    localparam int RADIX_W    = lsd_pkg::RADIX_W;
    localparam int NDIG_W     = lsd_pkg::NDIG_W;
    localparam int MAX_ITEMS  = lsd_pkg::MAX_ITEMS;
    localparam int MAX_RADIX  = lsd_pkg::MAX_RADIX;
    localparam int APB_ADDR_W = lsd_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = lsd_pkg::APB_DATA_W;

    localparam int STALL_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 480;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
        logic             ovf;
    } sorted_res_t;

    typedef struct {
        bit                 is_cfg;
        lsd_pkg::reg_idx_t  idx;
        logic [31:0]        val;
        logic [KEY_W-1:0]   key;
        bit                 last;
        bit                 typed;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    lsd_in_if  in_ch ();
    lsd_out_if out_ch ();

    lsd_radix_sort_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Sorter state mirrored in the bench
    logic [KEY_W-1:0]   batch_keys [MAX_ITEMS];
    int                 batch_count = 0;
    bit                 batch_ovf = 1'b0;
    logic [RADIX_W-1:0] cur_radix = lsd_pkg::RADIX_RST;
    logic [NDIG_W-1:0]  cur_ndig = lsd_pkg::NDIG_RST;

    sorted_res_t expected_sorted [$];
    int err_count = 0;
    int keys_sent = 0;
    int batches_sent = 0;
    int results_seen = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_cycles = 0;

    stim_row_t stim_table [$];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.key = '0;
        in_ch.last_item = 1'b0;
        out_ch.ready = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            sorted_res_t want;
            results_seen++;
            if (expected_sorted.size() == 0)
            begin
                $error("unexpected result: sorted_key %0h", out_ch.sorted_key);
                err_count++;
            end
            else
            begin
                want = expected_sorted.pop_front();
                if (out_ch.sorted_key !== want.key)
                begin
                    $error("sorted_key: expected %0h, got %0h", want.key, out_ch.sorted_key);
                    err_count++;
                end
                if (out_ch.last_out !== want.last)
                begin
                    $error("last_out: expected %0b, got %0b", want.last, out_ch.last_out);
                    err_count++;
                end
                if (out_ch.overflow !== want.ovf)
                begin
                    $error("overflow: expected %0b, got %0b", want.ovf, out_ch.overflow);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("** lsd_radix_sort_engine: FAILED **");
            $finish;
        end
    end

    // Stable LSD sort of the loaded batch, pushed as expected results when emit is set
    task automatic sort_and_expect(input bit emit);
        int unsigned r;
        longint unsigned weight;
        bit past;
        int counts [MAX_RADIX];
        logic [KEY_W-1:0] scratch [MAX_ITEMS];
        int d;
        sorted_res_t res;
        begin
            r = cur_radix;
            if (r < 2) r = 2;
            if (r > MAX_RADIX) r = MAX_RADIX;
            weight = 1;
            past = 1'b0;
            for (int p = 0; p < cur_ndig; p++)
            begin
                for (int j = 0; j < MAX_RADIX; j++) counts[j] = 0;
                for (int i = 0; i < batch_count; i++)
                begin
                    d = past ? 0 : int'((longint'(batch_keys[i]) / weight) % r);
                    counts[d]++;
                end
                for (int j = 1; j < r; j++) counts[j] += counts[j-1];
                for (int i = batch_count - 1; i >= 0; i--)
                begin
                    d = past ? 0 : int'((longint'(batch_keys[i]) / weight) % r);
                    counts[d]--;
                    scratch[counts[d]] = batch_keys[i];
                end
                for (int i = 0; i < batch_count; i++) batch_keys[i] = scratch[i];
                if (!past)
                begin
                    weight = weight * r;
                    if (weight > 64'h7FFF_FFFF) past = 1'b1;
                end
            end
            if (emit)
            begin
                for (int i = 0; i < batch_count; i++)
                begin
                    res.key = batch_keys[i];
                    res.last = (i == batch_count - 1);
                    res.ovf = batch_ovf;
                    expected_sorted.push_back(res);
                end
            end
            batch_count = 0;
            batch_ovf = 1'b0;
        end
    endtask

    // One key transfer; valid stays high across back-to-back transfers
    task automatic send_key(input logic [KEY_W-1:0] k, input bit l, input bit emit);
        begin
            if ($urandom_range(99) < tx_idle_pct)
            begin
                in_ch.valid <= 1'b0;
                do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
            end
            in_ch.valid <= 1'b1;
            in_ch.key <= k;
            in_ch.last_item <= l;
            do @(posedge clk); while (!in_ch.ready);
            keys_sent++;
            if (batch_count < MAX_ITEMS)
            begin
                batch_keys[batch_count] = k;
                batch_count++;
            end
            else
                batch_ovf = 1'b1;
            if (l)
            begin
                batches_sent++;
                sort_and_expect(emit);
            end
        end
    endtask

    // Drain outstanding results, then let the block go idle
    task automatic wait_idle;
        begin
            while (expected_sorted.size() != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // APB write then read-back of one register
    task automatic write_reg(input lsd_pkg::reg_idx_t idx, input logic [31:0] val);
        logic [31:0] rd;
        logic [31:0] mask;
        begin
            in_ch.valid <= 1'b0;
            wait_idle();
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= APB_ADDR_W'(4 * int'(idx));
            pwdata <= val;
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            pwrite <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            rd = prdata;
            psel <= 1'b0;
            penable <= 1'b0;
            mask = (idx == lsd_pkg::REG_RADIX) ? 32'h1FF : 32'h3F;
            if ((rd & mask) !== (val & mask))
            begin
                $error("register readback: expected %0h, got %0h", val & mask, rd & mask);
                err_count++;
            end
            if (idx == lsd_pkg::REG_RADIX)
                cur_radix = val[RADIX_W-1:0];
            else
                cur_ndig = val[NDIG_W-1:0];
        end
    endtask

    function automatic stim_row_t cfg_row(input lsd_pkg::reg_idx_t idx,
                                          input logic [31:0] val);
        stim_row_t row;
        row = '{1'b1, idx, val, '0, 1'b0, 1'b0};
        return row;
    endfunction

    function automatic stim_row_t key_row(input logic [KEY_W-1:0] k, input bit l,
                                          input bit typed);
        stim_row_t row;
        row = '{1'b0, lsd_pkg::REG_RADIX, 32'd0, k, l, typed};
        return row;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key;
        logic [KEY_W-1:0] k;
        case ($urandom_range(3))
            0: k = KEY_W'($urandom);
            1: k = KEY_W'($urandom_range(0, 15));
            2: k = KEY_W'($urandom_range(0, 999));
            default: k = ~(KEY_W'(1) << $urandom_range(0, KEY_W - 1));
        endcase
        return k;
    endfunction

    task automatic random_config;
        logic [31:0] rdx;
        logic [31:0] nd;
        begin
            case ($urandom_range(5))
                0: rdx = 2;
                1: rdx = 256;
                2: rdx = 16;
                3: rdx = $urandom_range(2, 256);
                4: rdx = $urandom_range(0, 511);
                default: rdx = 10;
            endcase
            nd = $urandom_range(0, 5);
            // deep pass counts only with a narrow radix to keep passes short
            if ($urandom_range(9) == 0)
            begin
                nd = $urandom_range(16, 32);
                rdx = $urandom_range(2, 4);
            end
            write_reg(lsd_pkg::REG_RADIX, rdx);
            write_reg(lsd_pkg::REG_NUM_DIGITS, nd);
        end
    endtask

    initial
    begin
        sorted_res_t typed_res;
        int sent;
        int blen;
        int nbatch;

        // Directed rows; single-key batches carry a typed expectation
        stim_table.push_back(key_row(31'd0, 1'b1, 1'b1));
        stim_table.push_back(key_row(31'h7FFF_FFFF, 1'b1, 1'b1));
        stim_table.push_back(key_row(31'd170, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'd45, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'd75, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'd90, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'd802, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'd24, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'd2, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'd66, 1'b1, 1'b0));
        stim_table.push_back(cfg_row(lsd_pkg::REG_RADIX, 32'd0));
        stim_table.push_back(cfg_row(lsd_pkg::REG_NUM_DIGITS, 32'd32));
        stim_table.push_back(key_row(31'h7FFF_FFFF, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'h5555_5555, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'd0, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'h2AAA_AAAA, 1'b1, 1'b0));
        stim_table.push_back(cfg_row(lsd_pkg::REG_RADIX, 32'd511));
        stim_table.push_back(cfg_row(lsd_pkg::REG_NUM_DIGITS, 32'd0));
        stim_table.push_back(key_row(31'd9, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'd3, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'd7, 1'b1, 1'b0));
        stim_table.push_back(cfg_row(lsd_pkg::REG_RADIX, 32'd256));
        stim_table.push_back(cfg_row(lsd_pkg::REG_NUM_DIGITS, 32'd4));
        stim_table.push_back(key_row(31'h0102_0304, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'h0000_0004, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'h0102_0304, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'h7F00_0000, 1'b1, 1'b0));
        stim_table.push_back(cfg_row(lsd_pkg::REG_RADIX, 32'd1));
        stim_table.push_back(cfg_row(lsd_pkg::REG_NUM_DIGITS, 32'd63));
        stim_table.push_back(key_row(31'd6, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'd5, 1'b0, 1'b0));
        stim_table.push_back(key_row(31'h4000_0000, 1'b1, 1'b0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 35;
        rx_idle_pct = 83;
        foreach (stim_table[i])
        begin
            if (stim_table[i].is_cfg)
                write_reg(stim_table[i].idx, stim_table[i].val);
            else
            begin
                send_key(stim_table[i].key, stim_table[i].last, !stim_table[i].typed);
                if (stim_table[i].typed)
                begin
                    typed_res = '{stim_table[i].key, 1'b1, 1'b0};
                    expected_sorted.push_back(typed_res);
                end
            end
        end

        // Random batches under three idling mixes
        for (int mode = 0; mode < 3; mode++)
        begin
            tx_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 83 : 0;
            rx_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 35 : 0;
            random_config();
            sent = 0;
            nbatch = 0;
            while (sent < RANDOM_ITEMS / 3)
            begin
                if (nbatch > 0 && $urandom_range(3) == 0)
                    random_config();
                if ($urandom_range(11) == 0)
                begin
                    case ($urandom_range(3))
                        0: blen = 64;
                        1: blen = 65;
                        2: blen = 70;
                        default: blen = $urandom_range(60, 70);
                    endcase
                end
                else
                    blen = $urandom_range(1, 16);
                for (int j = 0; j < blen; j++)
                    send_key(rand_key(), j == blen - 1, 1'b1);
                sent += blen;
                nbatch++;
            end
        end

        in_ch.valid <= 1'b0;
        wait_idle();

        $display("covered %0d keys in %0d batches, %0d sorted keys checked",
                 keys_sent, batches_sent, results_seen);
        $display("radix and pass-count extremes, overflow batches and three idling mixes");
        if (err_count == 0)
            $display("** lsd_radix_sort_engine: PASSED **");
        else
            $display("** lsd_radix_sort_engine: FAILED **");
        $finish;
    end

endmodule
